// ===== design/rgbypb_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbypb_pkg
// Shared widths, constants and coefficient helper for the RGB to YPbPr block.
// ----------------------------------------------------------------------------
package rgbypb_pkg;

    localparam int COMP_W        = 16;
    localparam int OUT_W         = 17;
    localparam int CFG_W         = 16;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;
    localparam int FRAC_BITS_DEF = 16;
    localparam int QUOT_W        = 18;
    localparam int OUT_SHIFT     = 16;
    localparam int OUT_ONE       = 65536;
    localparam int OUT_HALF      = 32768;

    localparam logic [CFG_W-1:0] MAX_VALUE_RST = 16'd255;

    // Register index, taken from paddr above the byte offset.
    localparam logic [APB_ADDR_W-3:0] REG_MAX_VALUE = '0;

    // BT.601 weights in millionths.
    localparam longint unsigned MICRO_SCALE = 64'd1000000;
    localparam longint unsigned Y_R_U  = 64'd299000;
    localparam longint unsigned Y_G_U  = 64'd587000;
    localparam longint unsigned Y_B_U  = 64'd114000;
    localparam longint unsigned PB_R_U = 64'd168736;
    localparam longint unsigned PB_G_U = 64'd331264;
    localparam longint unsigned HALF_U = 64'd500000;
    localparam longint unsigned PR_G_U = 64'd418688;
    localparam longint unsigned PR_B_U = 64'd81312;

    // Weight in millionths to a fixed-point constant, rounded to nearest.
    function automatic longint unsigned coef_fx(input longint unsigned micro,
                                                input int frac);
        return ((micro << frac) + (MICRO_SCALE / 2)) / MICRO_SCALE;
    endfunction

endpackage

// ===== design/rgbypb_ifs.sv =====
// ----------------------------------------------------------------------------
// rgbypb interfaces
// Valid/ready channels for pixel beats in and YPbPr beats out.
// ----------------------------------------------------------------------------
interface rgbypb_pix_if;
    import rgbypb_pkg::*;

    logic              valid;
    logic              ready;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rgbypb_res_if;
    import rgbypb_pkg::*;

    logic                    valid;
    logic                    ready;
    logic        [OUT_W-1:0] luma;
    logic signed [OUT_W-1:0] blue_diff;
    logic signed [OUT_W-1:0] red_diff;

    modport source (output valid, luma, blue_diff, red_diff, input ready);
    modport sink   (input valid, luma, blue_diff, red_diff, output ready);
endinterface

// ===== design/rgb_to_ypbpr_converter_top.sv =====
// ----------------------------------------------------------------------------
// rgb_to_ypbpr_converter_top
// BT.601 RGB to YPbPr conversion, one pixel per clock, normalised by max_value.
// ----------------------------------------------------------------------------
// The block takes one RGB pixel beat per clock while not stalled and
// returns one YPbPr beat per pixel, in order. Each component is first
// saturated to max_value (a zero max_value counts as one), weighted with
// the BT.601 coefficients held as fixed-point constants with FRAC_BITS
// fraction bits, and divided by max_value so that Y, Pb and Pr come out in
// units of 1/65536, rounded to nearest with halves away from zero and
// clamped to 0..65536 for Y and -32768..32768 for Pb and Pr. The sustained
// rate is one pixel per clock while the output buffer is not full. An
// accepted pixel passes through saturation, multiplication, summing and
// numerator preparation, then the divider (one quotient bit per stage, one
// lane per channel, all on the same divisor) and the output buffer, which
// holds two entries, so pixel.ready is a register output and the pipeline
// keeps accepting while one finished result waits. max_value lives at
// byte address 0 of the APB port and must only be written while the block
// holds no pixel in flight.
// ----------------------------------------------------------------------------
module rgb_to_ypbpr_converter_top #(
    parameter int FRAC_BITS = rgbypb_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rgbypb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rgbypb_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rgbypb_pkg::APB_DATA_W-1:0] prdata,
    output logic                              pready,
    rgbypb_pix_if.sink                        pixel,
    rgbypb_res_if.source                      result
);

    import rgbypb_pkg::*;

    // Coefficient, product, magnitude and numerator widths.
    localparam int CW   = FRAC_BITS;
    localparam int PW   = COMP_W + CW;
    localparam int MW   = PW + 2;
    localparam int SW   = MW + 1;
    localparam int NFW  = MW + OUT_SHIFT + 1;
    localparam int DVW  = COMP_W + QUOT_W;
    localparam int NSTG = 4 + QUOT_W;

    localparam logic [CW-1:0] C_Y_R  = CW'(coef_fx(Y_R_U, FRAC_BITS));
    localparam logic [CW-1:0] C_Y_G  = CW'(coef_fx(Y_G_U, FRAC_BITS));
    localparam logic [CW-1:0] C_Y_B  = CW'(coef_fx(Y_B_U, FRAC_BITS));
    localparam logic [CW-1:0] C_PB_R = CW'(coef_fx(PB_R_U, FRAC_BITS));
    localparam logic [CW-1:0] C_PB_G = CW'(coef_fx(PB_G_U, FRAC_BITS));
    localparam logic [CW-1:0] C_HALF = CW'(coef_fx(HALF_U, FRAC_BITS));
    localparam logic [CW-1:0] C_PR_G = CW'(coef_fx(PR_G_U, FRAC_BITS));
    localparam logic [CW-1:0] C_PR_B = CW'(coef_fx(PR_B_U, FRAC_BITS));

    typedef struct packed {
        logic        [OUT_W-1:0] luma;
        logic signed [OUT_W-1:0] blue_diff;
        logic signed [OUT_W-1:0] red_diff;
    } res_t;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; the port
    // never inserts wait states.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] max_value_reg;
    logic [CFG_W-1:0] max_value_next;
    logic [CFG_W-1:0] divisor;
    logic             cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[APB_ADDR_W-1:2] == REG_MAX_VALUE);

    always_comb
    begin
        max_value_next = max_value_reg;
        if (psel && penable && pwrite && pready && cfg_hit)
        begin
            max_value_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_value_reg <= MAX_VALUE_RST;
        end
        else
        begin
            max_value_reg <= max_value_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (cfg_hit)
        begin
            prdata = APB_DATA_W'(max_value_reg);
        end
    end

    // A zero full-scale value behaves as one.
    assign divisor = (max_value_reg == '0) ? CFG_W'(1) : max_value_reg;

    // ------------------------------------------------------------------
    // Pipeline control. Every stage moves together; the whole pipeline
    // holds only when the output buffer is full, so nothing is lost or
    // repeated under back-pressure.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_next;
    logic            en;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic            push;
    logic            pop;

    assign en          = (count_reg != 2'd2);
    assign pixel.ready = en;
    assign push        = en && valid_reg[NSTG-1];
    assign pop         = result.valid && result.ready;

    always_comb
    begin
        valid_next  = valid_reg;
        count_next  = count_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (en)
        begin
            valid_next = {valid_reg[NSTG-2:0], pixel.valid};
        end
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: saturate each component to the full-scale value.
    // ------------------------------------------------------------------
    logic [COMP_W-1:0] red_reg;
    logic [COMP_W-1:0] green_reg;
    logic [COMP_W-1:0] blue_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg   <= (pixel.red > divisor) ? divisor : pixel.red;
            green_reg <= (pixel.green > divisor) ? divisor : pixel.green;
            blue_reg  <= (pixel.blue > divisor) ? divisor : pixel.blue;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the nine coefficient products, each in its own register.
    // ------------------------------------------------------------------
    logic [PW-1:0] y_r_reg;
    logic [PW-1:0] y_g_reg;
    logic [PW-1:0] y_b_reg;
    logic [PW-1:0] pb_r_reg;
    logic [PW-1:0] pb_g_reg;
    logic [PW-1:0] pb_b_reg;
    logic [PW-1:0] pr_r_reg;
    logic [PW-1:0] pr_g_reg;
    logic [PW-1:0] pr_b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_r_reg  <= PW'(red_reg) * PW'(C_Y_R);
            y_g_reg  <= PW'(green_reg) * PW'(C_Y_G);
            y_b_reg  <= PW'(blue_reg) * PW'(C_Y_B);
            pb_r_reg <= PW'(red_reg) * PW'(C_PB_R);
            pb_g_reg <= PW'(green_reg) * PW'(C_PB_G);
            pb_b_reg <= PW'(blue_reg) * PW'(C_HALF);
            pr_r_reg <= PW'(red_reg) * PW'(C_HALF);
            pr_g_reg <= PW'(green_reg) * PW'(C_PR_G);
            pr_b_reg <= PW'(blue_reg) * PW'(C_PR_B);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: weighted sums, split into magnitude and sign so that the
    // divider rounds halves away from zero.
    // ------------------------------------------------------------------
    logic        [MW-1:0] y_sum;
    logic signed [SW-1:0] pb_sum;
    logic signed [SW-1:0] pr_sum;
    logic        [SW-1:0] pb_abs;
    logic        [SW-1:0] pr_abs;
    logic        [MW-1:0] mag_reg [3];
    logic                 neg_reg [3];

    always_comb
    begin
        y_sum  = MW'(y_r_reg) + MW'(y_g_reg) + MW'(y_b_reg);
        pb_sum = $signed(SW'(pb_b_reg)) - $signed(SW'(pb_r_reg))
                 - $signed(SW'(pb_g_reg));
        pr_sum = $signed(SW'(pr_r_reg)) - $signed(SW'(pr_g_reg))
                 - $signed(SW'(pr_b_reg));
        pb_abs = pb_sum[SW-1] ? SW'(-pb_sum) : SW'(pb_sum);
        pr_abs = pr_sum[SW-1] ? SW'(-pr_sum) : SW'(pr_sum);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg[0] <= y_sum;
            mag_reg[1] <= pb_abs[MW-1:0];
            mag_reg[2] <= pr_abs[MW-1:0];
            neg_reg[0] <= 1'b0;
            neg_reg[1] <= pb_sum[SW-1];
            neg_reg[2] <= pr_sum[SW-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: scale to output units and add half the divisor for
    // rounding. The divisor carries FRAC_BITS zero bits, which are
    // dropped from the numerator here so the divider works on max_value
    // alone.
    // ------------------------------------------------------------------
    logic [NFW-1:0] num_full [3];
    logic [DVW-1:0] num_reg  [3];
    logic           sgn_reg  [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            num_full[k] = (NFW'(mag_reg[k]) << OUT_SHIFT)
                          + (NFW'(divisor) << (FRAC_BITS - 1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                num_reg[k] <= num_full[k][FRAC_BITS +: DVW];
                sgn_reg[k] <= neg_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 4 to 21: one divider lane per output channel.
    // ------------------------------------------------------------------
    logic [QUOT_W-1:0] quot [3];
    logic              qneg [3];

    for (genvar k = 0; k < 3; k++) begin : g_lane
        rgbypb_div_pipe #(
            .QW (QUOT_W),
            .DW (COMP_W)
        ) u_div (
            .clk      (clk),
            .en       (en),
            .divisor  (divisor),
            .dividend (num_reg[k]),
            .neg_in   (sgn_reg[k]),
            .quotient (quot[k]),
            .neg_out  (qneg[k])
        );
    end

    // ------------------------------------------------------------------
    // Clamp, restore the sign and write into the output buffer.
    // ------------------------------------------------------------------
    logic [OUT_W-1:0] pb_mag;
    logic [OUT_W-1:0] pr_mag;
    res_t             res_new;
    res_t             buf_reg [2];

    always_comb
    begin
        pb_mag = (quot[1] > QUOT_W'(OUT_HALF)) ? OUT_W'(OUT_HALF) : quot[1][OUT_W-1:0];
        pr_mag = (quot[2] > QUOT_W'(OUT_HALF)) ? OUT_W'(OUT_HALF) : quot[2][OUT_W-1:0];
        res_new.luma      = (quot[0] > QUOT_W'(OUT_ONE)) ? OUT_W'(OUT_ONE)
                                                        : quot[0][OUT_W-1:0];
        res_new.blue_diff = qneg[1] ? $signed(-pb_mag) : $signed(pb_mag);
        res_new.red_diff  = qneg[2] ? $signed(-pr_mag) : $signed(pr_mag);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= res_new;
        end
    end

    assign result.valid     = (count_reg != 2'd0);
    assign result.luma      = buf_reg[rd_ptr_reg].luma;
    assign result.blue_diff = buf_reg[rd_ptr_reg].blue_diff;
    assign result.red_diff  = buf_reg[rd_ptr_reg].red_diff;

endmodule

// ===== design/rgbypb_div_pipe.sv =====
// ----------------------------------------------------------------------------
// rgbypb_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with a sign tag.
// ----------------------------------------------------------------------------
module rgbypb_div_pipe #(
    parameter int QW = rgbypb_pkg::QUOT_W,
    parameter int DW = rgbypb_pkg::COMP_W
) (
    input  logic             clk,
    input  logic             en,
    input  logic [DW-1:0]    divisor,
    input  logic [DW+QW-1:0] dividend,
    input  logic             neg_in,
    output logic [QW-1:0]    quotient,
    output logic             neg_out
);

    // The remainder sits above the dividend bits still to be brought down;
    // quotient bits shift in from the bottom as dividend bits leave the top.
    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] rest_reg [QW];
    logic          neg_reg  [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] rest_in;
        logic          sign_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          fit;

        if (i == 0) begin : g_first
            assign rem_in  = dividend[DW+QW-1:QW];
            assign rest_in = dividend[QW-1:0];
            assign sign_in = neg_in;
        end
        else begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign rest_in = rest_reg[i-1];
            assign sign_in = neg_reg[i-1];
        end

        always_comb
        begin
            trial = {rem_in, rest_in[QW-1]};
            diff  = trial - {1'b0, divisor};
            fit   = (trial >= {1'b0, divisor});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= fit ? diff[DW-1:0] : trial[DW-1:0];
                rest_reg[i] <= {rest_in[QW-2:0], fit};
                neg_reg[i]  <= sign_in;
            end
        end
    end

    assign quotient = rest_reg[QW-1];
    assign neg_out  = neg_reg[QW-1];

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the BT.601 RGB to YPbPr converter.
// ----------------------------------------------------------------------------
// Pixel beats are sent through the valid/ready input channel. Each accepted
// pixel is converted by a predictor in this file, and the prediction is queued.
// A receiver process with random stalls takes the YPbPr beats and compares
// each one with the oldest queued prediction. The scale register is written
// over the APB port between bursts, and each value written is read back.
// ----------------------------------------------------------------------------
module tb;
    import rgbypb_pkg::*;

    localparam int          CLK_HALF    = 6;
    localparam int          RESET_LEN   = 11;
    localparam int          FRAC        = FRAC_BITS_DEF;
    localparam int          TAIL_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT = 400000;

    // The scale register sits at byte offset 0.
    localparam logic [APB_ADDR_W-1:0] MAX_VALUE_ADDR = {REG_MAX_VALUE, 2'b00};

    typedef struct {
        logic        [OUT_W-1:0] luma;
        logic signed [OUT_W-1:0] blue_diff;
        logic signed [OUT_W-1:0] red_diff;
    } ypbpr_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rgbypb_pix_if pix_bus ();
    rgbypb_res_if res_bus ();

    rgb_to_ypbpr_converter_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pixel   (pix_bus),
        .result  (res_bus)
    );

    // Our copy of the scale register, used by the predictor.
    int unsigned scale_max = MAX_VALUE_RST;

    // Predicted YPbPr beats, oldest first.
    ypbpr_t pending_ypbpr[$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // Idle controls. The sender and the receiver each draw a gap per beat
    // while their flag is set; hold_request asks the receiver for one long
    // hold-off, which it counts down on its own.
    bit          src_idle_on  = 1'b1;
    bit          sink_idle_on = 1'b1;
    int unsigned hold_request = 0;

    // ------------------------------------------------------------------------
    // Clock and the overall time limit.
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------------

    // A weight in millionths becomes a constant with FRAC fraction bits,
    // rounded to nearest.
    function automatic longint fx_weight(input longint micro);
        return ((micro << FRAC) + 500000) / 1000000;
    endfunction

    // Scales a weighted sum to units of 1/65536 and divides it by the
    // denominator, rounding halves away from zero.
    function automatic longint div_round(input longint num, input longint den);
        longint mag;
        longint quot;
        mag  = (num < 0) ? -num : num;
        quot = (mag * OUT_ONE + den / 2) / den;
        return (num < 0) ? -quot : quot;
    endfunction

    function automatic ypbpr_t predict_ypbpr(input logic [COMP_W-1:0] r_in,
                                             input logic [COMP_W-1:0] g_in,
                                             input logic [COMP_W-1:0] b_in);
        longint full;
        longint r;
        longint g;
        longint b;
        longint den;
        longint y_val;
        longint pb_val;
        longint pr_val;
        ypbpr_t res;

        // A zero scale behaves as one; components above the scale saturate.
        full = (scale_max == 0) ? 1 : longint'(scale_max);
        r    = (longint'(r_in) > full) ? full : longint'(r_in);
        g    = (longint'(g_in) > full) ? full : longint'(g_in);
        b    = (longint'(b_in) > full) ? full : longint'(b_in);
        den  = full << FRAC;

        y_val  = div_round(fx_weight(299000) * r + fx_weight(587000) * g
                           + fx_weight(114000) * b, den);
        pb_val = div_round(fx_weight(500000) * b - fx_weight(168736) * r
                           - fx_weight(331264) * g, den);
        pr_val = div_round(fx_weight(500000) * r - fx_weight(418688) * g
                           - fx_weight(81312) * b, den);

        // Rounded coefficients may push a result just past its range.
        if (y_val < 0) y_val = 0;
        if (y_val > OUT_ONE) y_val = OUT_ONE;
        if (pb_val < -OUT_HALF) pb_val = -OUT_HALF;
        if (pb_val > OUT_HALF) pb_val = OUT_HALF;
        if (pr_val < -OUT_HALF) pr_val = -OUT_HALF;
        if (pr_val > OUT_HALF) pr_val = OUT_HALF;

        res.luma      = y_val[OUT_W-1:0];
        res.blue_diff = pb_val[OUT_W-1:0];
        res.red_diff  = pr_val[OUT_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: takes YPbPr beats with random stalls and checks each one
    // against the oldest prediction.
    // ------------------------------------------------------------------------
    int unsigned stall_left = 0;
    int unsigned hold_left  = 0;

    always @(posedge clk)
    begin
        ypbpr_t want;
        if (rst_n)
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                if (pending_ypbpr.size() == 0)
                begin
                    $error("YPbPr beat arrived with no pixel outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_ypbpr.pop_front();
                    if (res_bus.luma !== want.luma)
                    begin
                        $error("luma: expected %0d, got %0d", want.luma, res_bus.luma);
                        mismatch_count++;
                    end
                    if (res_bus.blue_diff !== want.blue_diff)
                    begin
                        $error("blue_diff: expected %0d, got %0d",
                               want.blue_diff, res_bus.blue_diff);
                        mismatch_count++;
                    end
                    if (res_bus.red_diff !== want.red_diff)
                    begin
                        $error("red_diff: expected %0d, got %0d",
                               want.red_diff, res_bus.red_diff);
                        mismatch_count++;
                    end
                end
                stall_left = sink_idle_on ? $urandom_range(0, 7) : 0;
            end

            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end

            if (hold_left != 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                res_bus.ready <= 1'b0;
            end
            else
            begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Shared tasks.
    // ------------------------------------------------------------------------

    // Offers one pixel beat and queues its prediction once it is accepted.
    // valid stays high afterwards, so a following beat with no gap goes out
    // back to back; the caller ends every burst with wait_for_results.
    task automatic send_pixel(input logic [COMP_W-1:0] r,
                              input logic [COMP_W-1:0] g,
                              input logic [COMP_W-1:0] b);
        int unsigned gap;
        gap = src_idle_on ? $urandom_range(0, 7) : 0;
        if (gap != 0)
        begin
            pix_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.red   <= r;
        pix_bus.green <= g;
        pix_bus.blue  <= b;
        do @(posedge clk); while (!pix_bus.ready);
        pending_ypbpr.push_back(predict_ypbpr(r, g, b));
    endtask

    // Stops offering pixels and waits until every predicted beat has come.
    task automatic wait_for_results();
        pix_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_ypbpr.size() != 0) @(posedge clk);
    endtask

    task automatic read_max_value(input logic [CFG_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= MAX_VALUE_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[CFG_W-1:0] !== want)
        begin
            $error("max_value: expected %0d, got %0d", want, prdata[CFG_W-1:0]);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Writes the scale register while the block is idle, then reads it back.
    task automatic set_scale(input logic [CFG_W-1:0] value);
        wait_for_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_VALUE_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        scale_max  = value;
        @(posedge clk);
        read_max_value(value);
    endtask

    // A component for random traffic: mostly within the scale, some at the
    // ends of it and some anywhere in the 16-bit range, so that saturation
    // and every input bit get exercised.
    function automatic logic [COMP_W-1:0] random_component();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return COMP_W'(scale_max);
            2, 3:    return COMP_W'($urandom);
            default: return COMP_W'($urandom_range(0, scale_max));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Reset value of the scale register, then primaries, secondaries, black,
    // white, grey and components above the scale at the reset scale of 255.
    task automatic test_reset_scale();
        read_max_value(MAX_VALUE_RST);
        send_pixel(16'd0,     16'd0,     16'd0);
        send_pixel(16'd255,   16'd255,   16'd255);
        send_pixel(16'd255,   16'd0,     16'd0);
        send_pixel(16'd0,     16'd255,   16'd0);
        send_pixel(16'd0,     16'd0,     16'd255);
        send_pixel(16'd255,   16'd255,   16'd0);
        send_pixel(16'd0,     16'd255,   16'd255);
        send_pixel(16'd255,   16'd0,     16'd255);
        send_pixel(16'd128,   16'd128,   16'd128);
        send_pixel(16'd256,   16'd0,     16'd0);
        send_pixel(16'd65535, 16'd65535, 16'd65535);
        wait_for_results();
    endtask

    // A zero scale counts as one, so any nonzero component is full scale.
    task automatic test_zero_scale();
        set_scale(16'd0);
        send_pixel(16'd0,     16'd0,     16'd0);
        send_pixel(16'd1,     16'd0,     16'd0);
        send_pixel(16'd0,     16'd0,     16'd65535);
        send_pixel(16'd65535, 16'd65535, 16'd65535);
        wait_for_results();
    endtask

    task automatic test_unit_scale();
        set_scale(16'd1);
        send_pixel(16'd1, 16'd0, 16'd0);
        send_pixel(16'd0, 16'd1, 16'd1);
        send_pixel(16'd2, 16'd2, 16'd2);
        wait_for_results();
    endtask

    task automatic test_full_scale();
        set_scale(16'd65535);
        send_pixel(16'd65535, 16'd0,     16'd0);
        send_pixel(16'd0,     16'd65535, 16'd0);
        send_pixel(16'd0,     16'd0,     16'd65535);
        send_pixel(16'd65535, 16'd65535, 16'd65535);
        send_pixel(16'd32768, 16'd32767, 16'd1);
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering back to back, so the pipeline fills and stalls its input.
    task automatic test_backpressure();
        set_scale(16'd1023);
        src_idle_on  = 1'b0;
        hold_request = 400;
        repeat (60) send_pixel(random_component(), random_component(),
                               random_component());
        wait_for_results();
        src_idle_on = 1'b1;
    endtask

    // Random pixels over several scales. Idling on either side is switched
    // on and off in chunks, and one phase pauses the sender half way until
    // every result is in.
    task automatic test_random_scales();
        logic [CFG_W-1:0] scales[7];
        scales[0] = CFG_W'($urandom_range(2, 65534));
        scales[1] = 16'd255;
        scales[2] = 16'd4095;
        scales[3] = 16'd65535;
        scales[4] = 16'd1;
        scales[5] = 16'd7;
        scales[6] = CFG_W'($urandom_range(2, 65534));
        foreach (scales[p])
        begin
            set_scale(scales[p]);
            for (int n = 0; n < 115; n++)
            begin
                if (n % 40 == 0)
                begin
                    src_idle_on  = ($urandom_range(0, 3) != 0);
                    sink_idle_on = ($urandom_range(0, 3) != 0);
                end
                if (p == 2 && n == 57)
                    wait_for_results();
                send_pixel(random_component(), random_component(),
                           random_component());
            end
        end
        wait_for_results();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        pix_bus.valid = 1'b0;
        pix_bus.red   = '0;
        pix_bus.green = '0;
        pix_bus.blue  = '0;
        res_bus.ready = 1'b0;

        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_scale();
        test_zero_scale();
        test_unit_scale();
        test_full_scale();
        test_backpressure();
        test_random_scales();

        // Let anything still in the pipeline show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
design/rgbypb_pkg.sv
design/rgbypb_ifs.sv
design/rgbypb_div_pipe.sv
design/rgb_to_ypbpr_converter_top.sv
test/tb.sv
